// ===== hw/rtl/websocket_frame_deframer_assert.svh =====
// assertion macros shared by the websocket deframer rtl
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define WSFD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wsfd assertion failed");

// next-cycle implication, held off while reset is low
`define WSFD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wsfd assertion failed");

`endif

// ===== hw/rtl/wsfd_pkg.sv =====
// types and constants of the websocket frame deframer
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

    // width that the decoded length is saturated to
    localparam int LENGTH_BITS = 64;
    localparam logic [63:0] LENGTH_MAX =
        (LENGTH_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << LENGTH_BITS) - 64'd1);

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // header byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4,
        PH_DROP = 3'd5
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] frame_len;
        logic [7:0]  out_byte;
        logic        last;
    } result_t;

    // clamp a decoded length to the supported range
    function automatic logic [63:0] sat_len(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        if ((v & ~LENGTH_MAX) != 64'd0) begin
            r = LENGTH_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsfd_core.sv =====
// header parser, length and key capture, payload unmasking
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module wsfd_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              take,
    input  wire logic              start_of_buffer,
    input  wire logic [7:0]        in_byte,
    output wsfd_pkg::result_t      res,
    output logic                   res_valid
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic        mask_reg, mask_next;
    logic [63:0] length_reg, length_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] left_reg, left_next;
    logic [1:0]  mpos_reg, mpos_next;

    // shared decode
    logic [6:0]  code;
    logic        code_ext;
    logic [3:0]  count_dec;
    logic [63:0] ext_len;
    logic [63:0] done_len;
    logic        hdr_mask;
    logic        length_done;
    logic        key_done;
    logic        emit_hdr;
    logic [63:0] hdr_len;
    logic        data_beat;
    logic [7:0]  key_byte;

    always_comb begin
        code      = in_byte[6:0];
        code_ext  = (code == wsfd_pkg::LEN_CODE_EXT16) || (code == wsfd_pkg::LEN_CODE_EXT64);
        count_dec = count_reg - 4'd1;
        ext_len   = {length_reg[55:0], in_byte};
        done_len  = wsfd_pkg::sat_len((phase_reg == wsfd_pkg::PH_LEN) ? {57'd0, code} : ext_len);
        hdr_mask  = (phase_reg == wsfd_pkg::PH_LEN) ? in_byte[7] : mask_reg;
        length_done = take && !start_of_buffer &&
            (((phase_reg == wsfd_pkg::PH_LEN) && !code_ext) ||
             ((phase_reg == wsfd_pkg::PH_EXT) && (count_dec == 4'd0)));
        key_done  = take && !start_of_buffer &&
            (phase_reg == wsfd_pkg::PH_KEY) && (count_dec == 4'd0);
        emit_hdr  = (length_done && !hdr_mask) || key_done;
        hdr_len   = key_done ? length_reg : done_len;
        data_beat = take && !start_of_buffer && (phase_reg == wsfd_pkg::PH_DATA);
        case (mpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next state
    always_comb begin
        phase_next      = phase_reg;
        first_byte_next = first_byte_reg;
        mask_next       = mask_reg;
        length_next     = length_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        left_next       = left_reg;
        mpos_next       = mpos_reg;
        if (take) begin
            if (start_of_buffer) begin
                first_byte_next = in_byte;
                mask_next       = 1'b0;
                length_next     = 64'd0;
                count_next      = 4'd0;
                key_next        = 32'd0;
                left_next       = 64'd0;
                mpos_next       = 2'd0;
                phase_next      = wsfd_pkg::PH_LEN;
            end else begin
                case (phase_reg)
                    wsfd_pkg::PH_LEN: begin
                        mask_next   = in_byte[7];
                        length_next = 64'd0;
                        if (code == wsfd_pkg::LEN_CODE_EXT16) begin
                            count_next = wsfd_pkg::EXT16_BYTES;
                            phase_next = wsfd_pkg::PH_EXT;
                        end else if (code == wsfd_pkg::LEN_CODE_EXT64) begin
                            count_next = wsfd_pkg::EXT64_BYTES;
                            phase_next = wsfd_pkg::PH_EXT;
                        end
                    end
                    wsfd_pkg::PH_EXT: begin
                        length_next = ext_len;
                        count_next  = count_dec;
                    end
                    wsfd_pkg::PH_KEY: begin
                        key_next   = {key_reg[23:0], in_byte};
                        count_next = count_dec;
                    end
                    wsfd_pkg::PH_DATA: begin
                        mpos_next = mpos_reg + 2'd1;
                        if (left_reg != 64'd0) begin
                            left_next = left_reg - 64'd1;
                        end
                        if (left_reg <= 64'd1) begin
                            phase_next = wsfd_pkg::PH_DROP;
                        end
                    end
                    default: begin
                    end
                endcase
                if (length_done) begin
                    length_next = done_len;
                    if (hdr_mask) begin
                        count_next = wsfd_pkg::KEY_BYTES;
                        key_next   = 32'd0;
                        phase_next = wsfd_pkg::PH_KEY;
                    end
                end
                if (emit_hdr) begin
                    left_next  = hdr_len;
                    mpos_next  = 2'd0;
                    phase_next = (hdr_len == 64'd0) ? wsfd_pkg::PH_DROP : wsfd_pkg::PH_DATA;
                end
            end
        end
    end

    // result of this beat
    always_comb begin
        res_valid          = emit_hdr || data_beat;
        res.kind           = data_beat ? wsfd_pkg::KIND_PAYLOAD : wsfd_pkg::KIND_HEADER;
        res.fin            = first_byte_reg[7];
        res.rsv            = first_byte_reg[6:4];
        res.opcode         = first_byte_reg[3:0];
        res.masked         = data_beat ? mask_reg : hdr_mask;
        res.frame_len      = data_beat ? length_reg : hdr_len;
        res.out_byte       = 8'd0;
        res.last           = 1'b0;
        if (data_beat) begin
            res.out_byte = mask_reg ? (in_byte ^ key_byte) : in_byte;
            res.last     = (left_reg <= 64'd1);
        end else begin
            res.last     = (hdr_len == 64'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wsfd_pkg::PH_IDLE;
            count_reg <= 4'd0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_byte_reg <= first_byte_next;
        mask_reg       <= mask_next;
        length_reg     <= length_next;
        key_reg        <= key_next;
        left_reg       <= left_next;
        mpos_reg       <= mpos_next;
    end

    `WSFD_ASSERT_IMP(a_no_result_when_dropping, aclk, aresetn,
        take && !start_of_buffer &&
        ((phase_reg == wsfd_pkg::PH_IDLE) || (phase_reg == wsfd_pkg::PH_DROP)),
        !res_valid)
    `WSFD_ASSERT_IMP(a_hdr_last_means_empty, aclk, aresetn,
        res_valid && (res.kind == wsfd_pkg::KIND_HEADER) && res.last,
        res.frame_len == 64'd0)
    `WSFD_ASSERT_NXT(a_last_ends_frame, aclk, aresetn,
        res_valid && res.last, phase_reg == wsfd_pkg::PH_DROP)
    `WSFD_ASSERT_NXT(a_start_restarts, aclk, aresetn,
        take && start_of_buffer, phase_reg == wsfd_pkg::PH_LEN)

endmodule

`default_nettype wire

// ===== hw/rtl/wsfd_skid.sv =====
// two-entry output register that keeps the input side running under stall
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module wsfd_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire wsfd_pkg::result_t in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output wsfd_pkg::result_t      out_data,
    input  wire logic              out_ready
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    wsfd_pkg::result_t main_reg, main_next;
    wsfd_pkg::result_t skid_reg, skid_next;
    logic              in_fire;
    logic              load;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign load      = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (load) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = in_data;
                main_valid_next = in_fire;
            end
        end else if (in_fire) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `WSFD_ASSERT_IMP(a_skid_behind_main, aclk, aresetn,
        skid_valid_reg, main_valid_reg)
    `WSFD_ASSERT_NXT(a_stall_fills_skid, aclk, aresetn,
        main_valid_reg && !out_ready && in_fire, skid_valid_reg)
    `WSFD_ASSERT_NXT(a_drain_empties, aclk, aresetn,
        main_valid_reg && out_ready && !skid_valid_reg && !in_fire, !main_valid_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// top level of the websocket (rfc 6455) frame deframer
// usage:
//   s_ channel: one received byte per beat; s_start_of_buffer marks the first
//   byte of a buffer and restarts the parser with that byte as header byte one
//   m_ channel: at most one result per input beat; a header result (m_kind 0)
//   once the length and masking key are known, then one beat per payload byte
//   with the mask removed; m_last flags the final result of the frame
//   results are registered: m_ is driven from the output register, not the parser
//   throughput: one byte per cycle while s_ready is high, set by the
//   combinational parser update between the input handshake and the output register
//   bytes outside a frame (before a buffer start, after the payload) are
//   dropped without a result
//   reset (aresetn low, synchronous): parser waits for a buffer start, output
//   register empties
//   receiver stall: a two-entry output register takes the beat in flight, then
//   s_ready falls until m_ready drains it; nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_start_of_buffer,
    input  wire logic [7:0]  s_in_byte,
    // results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic             m_fin,
    output logic [2:0]       m_rsv,
    output logic [3:0]       m_opcode,
    output logic             m_masked,
    output logic [63:0]      m_frame_len,
    output logic [7:0]       m_out_byte,
    output logic             m_last
);

    wsfd_pkg::result_t res;
    wsfd_pkg::result_t out_data;
    logic              res_valid;
    logic              take;

    // beat accepted on the byte side
    assign take = s_valid && s_ready;

    // parser: state update and combinational result for this beat
    wsfd_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .take            (take),
        .start_of_buffer (s_start_of_buffer),
        .in_byte         (s_in_byte),
        .res             (res),
        .res_valid       (res_valid)
    );

    // output register with a skid entry, ready is registered
    wsfd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    // result fields onto their ports
    assign m_kind           = out_data.kind;
    assign m_fin            = out_data.fin;
    assign m_rsv            = out_data.rsv;
    assign m_opcode         = out_data.opcode;
    assign m_masked         = out_data.masked;
    assign m_frame_len      = out_data.frame_len;
    assign m_out_byte       = out_data.out_byte;
    assign m_last           = out_data.last;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench of the websocket frame deframer: byte stream in, decoded frame results out
`timescale 1ns / 1ps

module tb;

    // cycles without any beat before the run is declared hung
    localparam int STALL_LIMIT = 400;
    // once this few bytes are left to send, both sides stop idling
    localparam int CALM_TAIL = 60;
    // quiet cycles after the last result
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       sob;
        logic [7:0] raw;
    } rx_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_start_of_buffer = 1'b0;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic        m_fin;
    logic [2:0]  m_rsv;
    logic [3:0]  m_opcode;
    logic        m_masked;
    logic [63:0] m_frame_len;
    logic [7:0]  m_out_byte;
    logic        m_last;

    // bytes still to send, and decoded results still due from the block
    rx_byte_t          rx_bytes[$];
    wsfd_pkg::result_t decoded_q[$];

    int  total_bytes = 0;
    int  bytes_taken = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  feed_gap = 0;
    int  sink_stall = 0;
    logic byte_taken = 1'b0;

    // deframer state as the testbench tracks it
    wsfd_pkg::phase_t frame_phase = wsfd_pkg::PH_IDLE;
    logic [7:0]  hdr_byte = 8'h00;
    logic        key_on = 1'b0;
    logic [63:0] len_acc = 64'd0;
    logic [3:0]  hdr_left = 4'd0;
    logic [31:0] mask_word = 32'd0;
    logic [63:0] remaining = 64'd0;
    logic [1:0]  key_idx = 2'd0;

    websocket_frame_deframer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_of_buffer (s_start_of_buffer),
        .s_in_byte         (s_in_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_fin             (m_fin),
        .m_rsv             (m_rsv),
        .m_opcode          (m_opcode),
        .m_masked          (m_masked),
        .m_frame_len       (m_frame_len),
        .m_out_byte        (m_out_byte),
        .m_last            (m_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // frame decoding as the block should do it
    // ---------------------------------------------------------------

    // header fields of the current frame, repeated on every result
    function automatic wsfd_pkg::result_t frame_fields(input logic kind,
                                                       input logic [7:0] data,
                                                       input logic last);
        wsfd_pkg::result_t r;
        r.kind           = kind;
        r.fin            = hdr_byte[7];
        r.rsv            = hdr_byte[6:4];
        r.opcode         = hdr_byte[3:0];
        r.masked         = key_on;
        r.frame_len      = len_acc;
        r.out_byte       = data;
        r.last           = last;
        return r;
    endfunction

    // header complete: announce it, a zero-length frame ends right here
    function automatic bit open_payload(output wsfd_pkg::result_t r);
        remaining = len_acc;
        key_idx   = 2'd0;
        if (len_acc == 64'd0) begin
            frame_phase = wsfd_pkg::PH_DROP;
            r = frame_fields(wsfd_pkg::KIND_HEADER, 8'h00, 1'b1);
        end else begin
            frame_phase = wsfd_pkg::PH_DATA;
            r = frame_fields(wsfd_pkg::KIND_HEADER, 8'h00, 1'b0);
        end
        return 1'b1;
    endfunction

    // length known: clamp it, then either collect the key or start the payload
    function automatic bit close_length(output wsfd_pkg::result_t r);
        r = '0;
        if (len_acc > wsfd_pkg::LENGTH_MAX) begin
            len_acc = wsfd_pkg::LENGTH_MAX;
        end
        if (key_on) begin
            hdr_left    = wsfd_pkg::KEY_BYTES;
            mask_word   = 32'd0;
            frame_phase = wsfd_pkg::PH_KEY;
            return 1'b0;
        end
        return open_payload(r);
    endfunction

    // one received byte in, at most one decoded result out
    function automatic bit deframe_byte(input logic sob, input logic [7:0] b,
                                        output wsfd_pkg::result_t r);
        bit         made;
        logic [7:0] v;
        logic       last;
        made = 1'b0;
        r    = '0;
        if (sob) begin
            // a buffer start always restarts, even mid-frame
            hdr_byte    = b;
            key_on      = 1'b0;
            len_acc     = 64'd0;
            hdr_left    = 4'd0;
            mask_word   = 32'd0;
            remaining   = 64'd0;
            key_idx     = 2'd0;
            frame_phase = wsfd_pkg::PH_LEN;
        end else begin
            case (frame_phase)
                wsfd_pkg::PH_LEN: begin
                    key_on  = b[7];
                    len_acc = 64'd0;
                    if (b[6:0] == wsfd_pkg::LEN_CODE_EXT16) begin
                        hdr_left    = wsfd_pkg::EXT16_BYTES;
                        frame_phase = wsfd_pkg::PH_EXT;
                    end else if (b[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
                        hdr_left    = wsfd_pkg::EXT64_BYTES;
                        frame_phase = wsfd_pkg::PH_EXT;
                    end else begin
                        len_acc = {57'd0, b[6:0]};
                        made    = close_length(r);
                    end
                end
                wsfd_pkg::PH_EXT: begin
                    // big-endian extended length, msb taken as is
                    len_acc  = {len_acc[55:0], b};
                    hdr_left = hdr_left - 4'd1;
                    if (hdr_left == 4'd0) begin
                        made = close_length(r);
                    end
                end
                wsfd_pkg::PH_KEY: begin
                    mask_word = {mask_word[23:0], b};
                    hdr_left  = hdr_left - 4'd1;
                    if (hdr_left == 4'd0) begin
                        made = open_payload(r);
                    end
                end
                wsfd_pkg::PH_DATA: begin
                    v = b;
                    if (key_on) begin
                        v = b ^ mask_word[31 - 8 * key_idx -: 8];
                    end
                    key_idx = key_idx + 2'd1;
                    last    = (remaining <= 64'd1);
                    if (remaining != 64'd0) begin
                        remaining = remaining - 64'd1;
                    end
                    if (last) begin
                        frame_phase = wsfd_pkg::PH_DROP;
                    end
                    r    = frame_fields(wsfd_pkg::KIND_PAYLOAD, v, last);
                    made = 1'b1;
                end
                default: begin
                    // idle or past the payload: byte dropped
                end
            endcase
        end
        return made;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    // one line per mismatch
    task automatic flag_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        mismatches = mismatches + 1;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic check_result(input wsfd_pkg::result_t got, input wsfd_pkg::result_t want);
        if (got.kind !== want.kind) flag_error("kind", 64'(got.kind), 64'(want.kind));
        if (got.fin !== want.fin) flag_error("fin", 64'(got.fin), 64'(want.fin));
        if (got.rsv !== want.rsv) flag_error("rsv", 64'(got.rsv), 64'(want.rsv));
        if (got.opcode !== want.opcode) begin
            flag_error("opcode", 64'(got.opcode), 64'(want.opcode));
        end
        if (got.masked !== want.masked) begin
            flag_error("masked", 64'(got.masked), 64'(want.masked));
        end
        if (got.frame_len !== want.frame_len) begin
            flag_error("frame_len", got.frame_len, want.frame_len);
        end
        if (got.out_byte !== want.out_byte) begin
            flag_error("out_byte", 64'(got.out_byte), 64'(want.out_byte));
        end
        if (got.last !== want.last) flag_error("last", 64'(got.last), 64'(want.last));
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic queue_byte(input logic sob, input logic [7:0] b);
        rx_byte_t it;
        it.sob = sob;
        it.raw = b;
        rx_bytes.insert(rx_bytes.size(), it);
    endtask

    // one frame with random header and content; some are cut short or
    // followed by stray bytes
    task automatic queue_random_frame();
        logic [7:0]  frame_bytes[$];
        logic [63:0] plen;
        logic [31:0] key;
        logic        mask_on;
        int          pick;
        int          n;
        int          i;
        mask_on = 1'($urandom_range(0, 1));
        plen    = 64'd0;
        frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            // short 7-bit length, zero and the 125 ceiling now and then
            if ($urandom_range(0, 19) == 0) plen = 64'd125;
            else if ($urandom_range(0, 9) == 0) plen = 64'd0;
            else plen = 64'($urandom_range(0, 24));
            frame_bytes.insert(frame_bytes.size(), {mask_on, plen[6:0]});
        end else if (pick < 8) begin
            // 16-bit length, mostly small so the payload finishes
            if ($urandom_range(0, 9) == 0) plen = 64'($urandom_range(0, 65535));
            else plen = 64'($urandom_range(0, 40));
            frame_bytes.insert(frame_bytes.size(), {mask_on, wsfd_pkg::LEN_CODE_EXT16});
            frame_bytes.insert(frame_bytes.size(), plen[15:8]);
            frame_bytes.insert(frame_bytes.size(), plen[7:0]);
        end else begin
            // 64-bit length, sometimes fully random, top bit included
            if ($urandom_range(0, 3) == 0) plen = {32'($urandom), 32'($urandom)};
            else plen = 64'($urandom_range(0, 40));
            frame_bytes.insert(frame_bytes.size(), {mask_on, wsfd_pkg::LEN_CODE_EXT64});
            for (i = 7; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), plen[8 * i +: 8]);
        end
        if (mask_on) begin
            key = 32'($urandom);
            for (i = 3; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), key[8 * i +: 8]);
        end
        // huge lengths send only a slice; the next buffer start abandons them
        n = (plen > 64'd48) ? 48 : int'(plen);
        for (i = 0; i < n; i++) begin
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
        end
        if (frame_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, frame_bytes.size() - 1);
        end else begin
            n = frame_bytes.size();
        end
        for (i = 0; i < n; i++) queue_byte(i == 0, frame_bytes[i]);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        for (i = 0; i < n; i++) queue_byte(1'b0, 8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // input side: beat detection and prediction at the rising edge
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : byte_accept
        wsfd_pkg::result_t due;
        if (!aresetn) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                if (deframe_byte(s_start_of_buffer, s_in_byte, due)) begin
                    decoded_q.insert(decoded_q.size(), due);
                end
                bytes_taken <= bytes_taken + 1;
            end
        end
    end

    // input driver, falling edge: hold until the beat goes, then maybe idle
    always @(negedge aclk) begin : byte_driver
        rx_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !byte_taken) begin
            // beat still waiting, payload stays put
        end else if (feed_gap > 0 && rx_bytes.size() >= CALM_TAIL) begin
            s_valid  <= 1'b0;
            feed_gap <= feed_gap - 1;
        end else if (rx_bytes.size() >= CALM_TAIL && $urandom_range(0, 11) == 0) begin
            // idle burst of random length, this one included
            s_valid  <= 1'b0;
            feed_gap <= $urandom_range(0, 17);
        end else if (rx_bytes.size() > 0) begin
            nxt = rx_bytes.pop_front();
            s_valid           <= 1'b1;
            s_start_of_buffer <= nxt.sob;
            s_in_byte         <= nxt.raw;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // result side: stall bursts on m_ready, compare at the rising edge
    // ---------------------------------------------------------------
    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_bytes.size() < CALM_TAIL) begin
            m_ready <= 1'b1;
        end else if (sink_stall > 0) begin
            m_ready    <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if ($urandom_range(0, 11) == 0) begin
            m_ready    <= 1'b0;
            sink_stall <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        wsfd_pkg::result_t got;
        wsfd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.kind           = m_kind;
            got.fin            = m_fin;
            got.rsv            = m_rsv;
            got.opcode         = m_opcode;
            got.masked         = m_masked;
            got.frame_len      = m_frame_len;
            got.out_byte       = m_out_byte;
            got.last           = m_last;
            if (decoded_q.size() == 0) begin
                flag_error("result with nothing due", 64'(got.out_byte), 64'd0);
            end else begin
                want = decoded_q.pop_front();
                check_result(got, want);
            end
        end
    end

    // watchdog: too long without a beat on either channel means a hang
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[websocket_frame_deframer] ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial begin : run
        int i;
        int n;

        // directed: stray bytes before any buffer start are dropped
        queue_byte(1'b0, 8'hA5);
        queue_byte(1'b0, 8'h00);
        // zero-length text frame: header carries last, trailing byte dropped
        queue_byte(1'b1, 8'h81);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'hFF);
        // masked binary frame of three bytes, payload extremes
        queue_byte(1'b1, 8'h82);
        queue_byte(1'b0, 8'h83);
        queue_byte(1'b0, 8'hDE);
        queue_byte(1'b0, 8'hAD);
        queue_byte(1'b0, 8'hBE);
        queue_byte(1'b0, 8'hEF);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'hFF);
        queue_byte(1'b0, 8'h5A);
        // 16-bit length of one, unmasked byte passes through
        queue_byte(1'b1, 8'h01);
        queue_byte(1'b0, 8'h7E);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h01);
        queue_byte(1'b0, 8'h3C);
        // fin clear, all rsv set, opcode 15, 64-bit length all ones with the
        // top bit set; one payload byte, then abandoned by the next buffer start
        queue_byte(1'b1, 8'h7F);
        queue_byte(1'b0, 8'h7F);
        for (i = 0; i < 8; i++) queue_byte(1'b0, 8'hFF);
        queue_byte(1'b0, 8'hC3);

        // random: mostly frames, some noise with stray buffer starts
        while (rx_bytes.size() < 480) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    queue_byte(1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)));
                end
            end else begin
                queue_random_frame();
            end
        end
        total_bytes = rx_bytes.size();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every byte taken, every due result seen, then a quiet drain
        wait (bytes_taken == total_bytes);
        wait (decoded_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            flag_error("results never delivered", 64'(decoded_q.size()), 64'd0);
        end

        if (mismatches == 0) begin
            $display("[websocket_frame_deframer] OK");
        end else begin
            $display("[websocket_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule
